FILE: hw/rtl/order_crossover_permutation_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for order_crossover_permutation
// Concurrent checks used by the RTL; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ORDER_CROSSOVER_PERMUTATION_ASSERT_SVH
`define ORDER_CROSSOVER_PERMUTATION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset
`define OCP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("order crossover check failed");

// Next-cycle implication, disabled in reset
`define OCP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("order crossover check failed");

`else

`define OCP_ASSERT_NOW(label, clk, rstn, ante, cons)
`define OCP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/ocp_pkg.sv
// ---------------------------------------------------------------------------
// ocp_pkg
// Shared widths and defaults for the order crossover block.
// ---------------------------------------------------------------------------
package ocp_pkg;

    // gene field width and the number of distinct gene codes
    localparam int GENE_W   = 6;
    localparam int GENE_CNT = 1 << GENE_W;

    // default longest parent held per set
    localparam int MAX_GENES_DEF = 64;

    typedef logic [GENE_W-1:0] gene_t;

endpackage

FILE: hw/rtl/order_crossover_permutation.sv
// ---------------------------------------------------------------------------
// order_crossover_permutation
// One-point order crossover (OX) of two parent permutations into two children.
// ---------------------------------------------------------------------------
// A set of n parent positions is loaded one beat per cycle (s_ready is high
// only while loading); the cut point is taken from the first beat of a set and
// the beat flagged s_last_position closes it. The block then walks the parent
// memories through their single read port: the copied prefix (positions 0..k,
// k = cut saturated to n-1), the fill pass over all n positions and a pipeline
// drain, and then streams n result beats at one per cycle when m_ready stays
// high. Loading of the next set starts as soon as the last result beat sits
// in the output register. m_bad_parents flags a gene >= n, a repeated gene in
// either parent, or beats beyond MAX_GENES (those are dropped); it is the same
// on every beat of a set. Positions left unfilled read as 0.
// ---------------------------------------------------------------------------
`include "order_crossover_permutation_assert.svh"

module order_crossover_permutation #(
    parameter int MAX_GENES = ocp_pkg::MAX_GENES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // parent beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ocp_pkg::gene_t        s_first_gene,
    input  ocp_pkg::gene_t        s_second_gene,
    input  ocp_pkg::gene_t        s_cut_point,
    input  logic                  s_last_position,
    // child beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output ocp_pkg::gene_t        m_child_one_gene,
    output ocp_pkg::gene_t        m_child_two_gene,
    output logic                  m_final_gene,
    output logic                  m_bad_parents
);

    localparam int AW    = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
    localparam int CW    = $clog2(MAX_GENES + 1);
    localparam int CMP_W = ocp_pkg::GENE_W + 1;
    localparam int GC    = ocp_pkg::GENE_CNT;

    // sequencer states
    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_PREFIX = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    // memories
    ocp_pkg::gene_t p1_mem [MAX_GENES];
    ocp_pkg::gene_t p2_mem [MAX_GENES];
    ocp_pkg::gene_t c1_mem [MAX_GENES];
    ocp_pkg::gene_t c2_mem [MAX_GENES];

    // control state
    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    ocp_pkg::gene_t     cut_reg, cut_next;
    logic               err_reg, err_next;
    logic [GC-1:0]      seen1_reg, seen1_next, seen2_reg, seen2_next;
    ocp_pkg::gene_t     max1_reg, max1_next, max2_reg, max2_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      k_reg, k_next;
    logic               bad_reg, bad_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic               pipe_fill_reg, pipe_fill_next;
    logic [AW-1:0]      pipe_pos_reg, pipe_pos_next;
    logic [GC-1:0]      used1_reg, used1_next, used2_reg, used2_next;
    logic [MAX_GENES-1:0] cv1_reg, cv1_next, cv2_reg, cv2_next;
    logic [CW-1:0]      fill1_reg, fill1_next, fill2_reg, fill2_next;
    logic [CW-1:0]      emit_cnt_reg, emit_cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic               o_final_reg, o_final_next;
    logic               o_bad_reg, o_bad_next;
    logic               o1_ok_reg, o1_ok_next, o2_ok_reg, o2_ok_next;

    // memory side
    ocp_pkg::gene_t     p1_rd_reg, p2_rd_reg;
    ocp_pkg::gene_t     o1_gene_reg, o2_gene_reg;

    // combinational helpers
    logic               in_acc, store_en, out_load;
    ocp_pkg::gene_t     cut_eff, max1_new, max2_new;
    logic [CW-1:0]      n_new;
    logic               dup1, dup2, err_new;
    logic               c1_we, c2_we;
    logic [AW-1:0]      c1_waddr, c2_waddr;
    ocp_pkg::gene_t     c1_wdata, c2_wdata;
    logic               new1, new2;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_acc   = s_valid && s_ready;
    assign store_en = in_acc && (cnt_reg < CW'(MAX_GENES));
    assign out_load = (state_reg == ST_EMIT) && (emit_cnt_reg != n_reg)
                      && (!m_valid_reg || m_ready);

    // load-time bookkeeping
    always_comb begin
        cut_eff  = (cnt_reg == '0) ? s_cut_point : cut_reg;
        n_new    = cnt_reg + CW'(store_en);
        dup1     = store_en && seen1_reg[s_first_gene];
        dup2     = store_en && seen2_reg[s_second_gene];
        max1_new = (store_en && (s_first_gene > max1_reg)) ? s_first_gene : max1_reg;
        max2_new = (store_en && (s_second_gene > max2_reg)) ? s_second_gene : max2_reg;
        err_new  = err_reg || (in_acc && !store_en) || dup1 || dup2;
    end

    // crossover datapath: prefix copy or ordered fill
    always_comb begin
        new1     = !used1_reg[p2_rd_reg];
        new2     = !used2_reg[p1_rd_reg];
        c1_we    = 1'b0;
        c2_we    = 1'b0;
        c1_waddr = pipe_pos_reg;
        c2_waddr = pipe_pos_reg;
        c1_wdata = p1_rd_reg;
        c2_wdata = p2_rd_reg;
        if (pipe_vld_reg && !pipe_fill_reg) begin
            c1_we = 1'b1;
            c2_we = 1'b1;
        end else if (pipe_vld_reg) begin
            c1_we    = new1 && (fill1_reg < n_reg);
            c2_we    = new2 && (fill2_reg < n_reg);
            c1_waddr = fill1_reg[AW-1:0];
            c2_waddr = fill2_reg[AW-1:0];
            c1_wdata = p2_rd_reg;
            c2_wdata = p1_rd_reg;
        end
    end

    // next-state logic
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cut_next       = cut_reg;
        err_next       = err_reg;
        seen1_next     = seen1_reg;
        seen2_next     = seen2_reg;
        max1_next      = max1_reg;
        max2_next      = max2_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        bad_next       = bad_reg;
        iss_next       = iss_reg;
        pipe_vld_next  = (state_reg == ST_PREFIX) || (state_reg == ST_FILL);
        pipe_fill_next = (state_reg == ST_FILL);
        pipe_pos_next  = iss_reg[AW-1:0];
        used1_next     = used1_reg;
        used2_next     = used2_reg;
        cv1_next       = cv1_reg;
        cv2_next       = cv2_reg;
        fill1_next     = fill1_reg;
        fill2_next     = fill2_reg;
        emit_cnt_next  = emit_cnt_reg;
        o_final_next   = o_final_reg;
        o_bad_next     = o_bad_reg;
        o1_ok_next     = o1_ok_reg;
        o2_ok_next     = o2_ok_reg;

        // output register
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        // processed walk beat
        if (pipe_vld_reg && !pipe_fill_reg) begin
            used1_next[p1_rd_reg]    = 1'b1;
            used2_next[p2_rd_reg]    = 1'b1;
            cv1_next[pipe_pos_reg]   = 1'b1;
            cv2_next[pipe_pos_reg]   = 1'b1;
        end else if (pipe_vld_reg) begin
            if (new1) begin
                used1_next[p2_rd_reg] = 1'b1;
                if (fill1_reg < n_reg) begin
                    cv1_next[fill1_reg[AW-1:0]] = 1'b1;
                    fill1_next = fill1_reg + CW'(1);
                end
            end
            if (new2) begin
                used2_next[p1_rd_reg] = 1'b1;
                if (fill2_reg < n_reg) begin
                    cv2_next[fill2_reg[AW-1:0]] = 1'b1;
                    fill2_next = fill2_reg + CW'(1);
                end
            end
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    cnt_next  = n_new;
                    cut_next  = cut_eff;
                    err_next  = err_new;
                    max1_next = max1_new;
                    max2_next = max2_new;
                    if (store_en) begin
                        seen1_next[s_first_gene]  = 1'b1;
                        seen2_next[s_second_gene] = 1'b1;
                    end
                    if (s_last_position) begin
                        n_next   = n_new;
                        bad_next = err_new
                                   || ({1'b0, max1_new} >= CMP_W'(n_new))
                                   || ({1'b0, max2_new} >= CMP_W'(n_new));
                        if ({1'b0, cut_eff} >= CMP_W'(n_new)) begin
                            k_next = AW'(n_new - CW'(1));
                        end else begin
                            k_next = AW'(cut_eff);
                        end
                        iss_next   = '0;
                        state_next = ST_PREFIX;
                    end
                end
            end
            ST_PREFIX: begin
                if (iss_reg == CW'(k_reg)) begin
                    iss_next   = '0;
                    fill1_next = CW'(k_reg) + CW'(1);
                    fill2_next = CW'(k_reg) + CW'(1);
                    state_next = ST_FILL;
                end else begin
                    iss_next = iss_reg + CW'(1);
                end
            end
            ST_FILL: begin
                if (iss_reg == n_reg - CW'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    iss_next = iss_reg + CW'(1);
                end
            end
            ST_DRAIN: begin
                emit_cnt_next = '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    emit_cnt_next = emit_cnt_reg + CW'(1);
                    o_final_next  = (emit_cnt_reg == n_reg - CW'(1));
                    o_bad_next    = bad_reg;
                    o1_ok_next    = cv1_reg[emit_cnt_reg[AW-1:0]];
                    o2_ok_next    = cv2_reg[emit_cnt_reg[AW-1:0]];
                    // last beat queued: clear the set and reopen loading
                    if (emit_cnt_reg == n_reg - CW'(1)) begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        cut_next   = '0;
                        err_next   = 1'b0;
                        seen1_next = '0;
                        seen2_next = '0;
                        max1_next  = '0;
                        max2_next  = '0;
                        used1_next = '0;
                        used2_next = '0;
                        cv1_next   = '0;
                        cv2_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            cut_reg       <= '0;
            err_reg       <= 1'b0;
            seen1_reg     <= '0;
            seen2_reg     <= '0;
            max1_reg      <= '0;
            max2_reg      <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            bad_reg       <= 1'b0;
            iss_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_fill_reg <= 1'b0;
            pipe_pos_reg  <= '0;
            used1_reg     <= '0;
            used2_reg     <= '0;
            cv1_reg       <= '0;
            cv2_reg       <= '0;
            fill1_reg     <= '0;
            fill2_reg     <= '0;
            emit_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
            o_final_reg   <= 1'b0;
            o_bad_reg     <= 1'b0;
            o1_ok_reg     <= 1'b0;
            o2_ok_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cut_reg       <= cut_next;
            err_reg       <= err_next;
            seen1_reg     <= seen1_next;
            seen2_reg     <= seen2_next;
            max1_reg      <= max1_next;
            max2_reg      <= max2_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            bad_reg       <= bad_next;
            iss_reg       <= iss_next;
            pipe_vld_reg  <= pipe_vld_next;
            pipe_fill_reg <= pipe_fill_next;
            pipe_pos_reg  <= pipe_pos_next;
            used1_reg     <= used1_next;
            used2_reg     <= used2_next;
            cv1_reg       <= cv1_next;
            cv2_reg       <= cv2_next;
            fill1_reg     <= fill1_next;
            fill2_reg     <= fill2_next;
            emit_cnt_reg  <= emit_cnt_next;
            m_valid_reg   <= m_valid_next;
            o_final_reg   <= o_final_next;
            o_bad_reg     <= o_bad_next;
            o1_ok_reg     <= o1_ok_next;
            o2_ok_reg     <= o2_ok_next;
        end
    end

    // parent memories: write while loading, registered read for the walk
    always_ff @(posedge aclk) begin
        if (store_en) begin
            p1_mem[cnt_reg[AW-1:0]] <= s_first_gene;
            p2_mem[cnt_reg[AW-1:0]] <= s_second_gene;
        end
        p1_rd_reg <= p1_mem[iss_reg[AW-1:0]];
        p2_rd_reg <= p2_mem[iss_reg[AW-1:0]];
    end

    // child memories: written by the walk, read straight into the output beat
    always_ff @(posedge aclk) begin
        if (c1_we) begin
            c1_mem[c1_waddr] <= c1_wdata;
        end
        if (c2_we) begin
            c2_mem[c2_waddr] <= c2_wdata;
        end
        if (out_load) begin
            o1_gene_reg <= c1_mem[emit_cnt_reg[AW-1:0]];
            o2_gene_reg <= c2_mem[emit_cnt_reg[AW-1:0]];
        end
    end

    // result beat; never-written positions read 0
    assign m_valid          = m_valid_reg;
    assign m_child_one_gene = o1_ok_reg ? o1_gene_reg : '0;
    assign m_child_two_gene = o2_ok_reg ? o2_gene_reg : '0;
    assign m_final_gene     = o_final_reg;
    assign m_bad_parents    = o_bad_reg;

    // checks
    `OCP_ASSERT_NEXT(a_last_beat_reopens, aclk, aresetn, out_load && (emit_cnt_reg == n_reg - CW'(1)), state_reg == ST_LOAD)
    `OCP_ASSERT_NOW(a_fill_bounded, aclk, aresetn, state_reg == ST_FILL || state_reg == ST_DRAIN, fill1_reg <= n_reg && fill2_reg <= n_reg)
    `OCP_ASSERT_NOW(a_prefix_in_cut, aclk, aresetn, pipe_vld_reg && !pipe_fill_reg, pipe_pos_reg <= k_reg)
    `OCP_ASSERT_NOW(a_emit_bounded, aclk, aresetn, state_reg == ST_EMIT, emit_cnt_reg < n_reg && CW'(k_reg) < n_reg)

endmodule

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: order crossover block testbench
// Loads parent sets (clean permutations, out-of-range genes, repeated genes,
// random noise, a full 64-position set and an overflowing set) through the
// parent channel. A local crossover predictor builds both children for every
// closed set. The monitor checks each child beat against the oldest predicted
// beat. Both channels idle in random bursts, the child sink holds off once for
// a long stretch, and the sender waits once for all children to drain.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT  = 4000;  // cycles without any accepted beat
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 60;    // child beats seen before the long hold
    localparam int TAIL_ITEMS   = 40;    // no idling while this few remain
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 230;

    typedef enum int {SET_CLEAN, SET_RANGE, SET_REPEAT, SET_NOISE} set_kind_t;

    typedef struct packed {
        ocp_pkg::gene_t first_gene;
        ocp_pkg::gene_t second_gene;
        ocp_pkg::gene_t cut_point;
        logic  last_position;
        logic  wait_drain;
    } parent_beat_t;

    typedef struct packed {
        ocp_pkg::gene_t child_one;
        ocp_pkg::gene_t child_two;
        logic  final_gene;
        logic  bad;
    } child_beat_t;

    // DUT ports
    logic  aclk            = 1'b0;
    logic  aresetn         = 1'b0;
    logic  s_valid         = 1'b0;
    logic  s_ready;
    ocp_pkg::gene_t s_first_gene    = '0;
    ocp_pkg::gene_t s_second_gene   = '0;
    ocp_pkg::gene_t s_cut_point     = '0;
    logic  s_last_position = 1'b0;
    logic  m_valid;
    logic  m_ready         = 1'b0;
    ocp_pkg::gene_t m_child_one_gene;
    ocp_pkg::gene_t m_child_two_gene;
    logic  m_final_gene;
    logic  m_bad_parents;

    // stimulus and scoreboard state
    parent_beat_t beat_q[$];
    child_beat_t  child_q[$];
    int items_queued   = 0;
    int sets_sent      = 0;
    int sets_done      = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;
    logic tail_quiet   = 1'b0;

    // crossover predictor state
    ocp_pkg::gene_t parent_mem [2][ocp_pkg::GENE_CNT];
    ocp_pkg::gene_t child_mem  [2][ocp_pkg::GENE_CNT];
    int    loaded_count  = 0;
    ocp_pkg::gene_t held_cut = '0;
    bit    overflow_seen = 1'b0;

    // idling state
    int src_gap = 0, src_phase_left = 0;
    bit src_chop = 1'b0;
    int snk_gap = 0, snk_phase_left = 0, hold_left = 0;
    bit snk_chop = 1'b0, hold_done = 1'b0;

    order_crossover_permutation u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_gene     (s_first_gene),
        .s_second_gene    (s_second_gene),
        .s_cut_point      (s_cut_point),
        .s_last_position  (s_last_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_child_one_gene (m_child_one_gene),
        .m_child_two_gene (m_child_two_gene),
        .m_final_gene     (m_final_gene),
        .m_bad_parents    (m_bad_parents)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Mismatch reporting
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH beat %0d: %s got %0d want %0d", results_seen, what, got, want);
        mismatch_count++;
    endtask

    // -----------------------------------------------------------------------
    // Crossover predictor
    // -----------------------------------------------------------------------
    // a gene past the set length or seen twice marks the parent bad
    function automatic bit parent_is_bad(input bit which, input int n);
        bit seen [ocp_pkg::GENE_CNT];
        bit bad;
        int g;
        bad = 1'b0;
        foreach (seen[i]) seen[i] = 1'b0;
        for (int i = 0; i < n; i++) begin
            g = parent_mem[which][i];
            if (g >= n || seen[g])
                bad = 1'b1;
            seen[g] = 1'b1;
        end
        return bad;
    endfunction

    // copy prefix 0..k from one parent, fill the rest in the other's order
    task automatic cross_child(input bit which, input int n, input int k);
        bit taken [ocp_pkg::GENE_CNT];
        int fill;
        int g;
        foreach (taken[i]) begin
            taken[i] = 1'b0;
            child_mem[which][i] = '0;
        end
        for (int i = 0; i <= k; i++) begin
            g = parent_mem[which][i];
            child_mem[which][i] = ocp_pkg::gene_t'(g);
            taken[g] = 1'b1;
        end
        fill = k + 1;
        for (int i = 0; i < n; i++) begin
            g = parent_mem[which ^ 1'b1][i];
            if (!taken[g]) begin
                if (fill < n)
                    child_mem[which][fill] = ocp_pkg::gene_t'(g);
                fill++;
                taken[g] = 1'b1;
            end
        end
    endtask

    // one accepted parent beat; a closing beat queues the whole child set
    task automatic absorb_parent_beat(input ocp_pkg::gene_t g1, input ocp_pkg::gene_t g2,
                                      input ocp_pkg::gene_t cut, input logic last);
        int n, k;
        bit bad;
        child_beat_t cb;
        if (loaded_count == 0)
            held_cut = cut;
        if (loaded_count < ocp_pkg::MAX_GENES_DEF) begin
            parent_mem[0][loaded_count] = g1;
            parent_mem[1][loaded_count] = g2;
            loaded_count++;
        end else begin
            overflow_seen = 1'b1;
        end
        if (!last)
            return;
        n = loaded_count;
        k = held_cut;
        if (k >= n)
            k = n - 1;
        bad = overflow_seen | parent_is_bad(1'b0, n) | parent_is_bad(1'b1, n);
        cross_child(1'b0, n, k);
        cross_child(1'b1, n, k);
        for (int i = 0; i < n; i++) begin
            cb.child_one  = child_mem[0][i];
            cb.child_two  = child_mem[1][i];
            cb.final_gene = (i == n - 1);
            cb.bad        = bad;
            child_q.push_back(cb);
        end
        loaded_count  = 0;
        held_cut      = '0;
        overflow_seen = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Stimulus builders
    // -----------------------------------------------------------------------
    task automatic push_beat(input int g1, input int g2, input int cut, input bit last,
                             input bit drain);
        parent_beat_t b;
        b.first_gene    = g1[ocp_pkg::GENE_W-1:0];
        b.second_gene   = g2[ocp_pkg::GENE_W-1:0];
        b.cut_point     = cut[ocp_pkg::GENE_W-1:0];
        b.last_position = last;
        b.wait_drain    = drain;
        beat_q.push_back(b);
        items_queued++;
    endtask

    // n positions; permutations of 0..n-1 damaged according to kind
    task automatic push_set(input int n, input int cut, input set_kind_t kind,
                            input bit drain);
        int pa [80];
        int pb [80];
        int span, i, j, tmp;
        span = (n > ocp_pkg::MAX_GENES_DEF) ? ocp_pkg::MAX_GENES_DEF : n;
        for (i = 0; i < span; i++) begin
            pa[i] = i;
            pb[i] = i;
        end
        for (i = span - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = pa[i]; pa[i] = pa[j]; pa[j] = tmp;
            j = $urandom_range(0, i);
            tmp = pb[i]; pb[i] = pb[j]; pb[j] = tmp;
        end
        // beats past the capacity carry random genes
        for (i = span; i < n; i++) begin
            pa[i] = $urandom_range(0, ocp_pkg::GENE_CNT - 1);
            pb[i] = $urandom_range(0, ocp_pkg::GENE_CNT - 1);
        end
        case (kind)
            SET_RANGE: begin
                if (n < ocp_pkg::GENE_CNT) begin
                    i = $urandom_range(0, n - 1);
                    if ($urandom_range(0, 1))
                        pa[i] = $urandom_range(n, ocp_pkg::GENE_CNT - 1);
                    else
                        pb[i] = $urandom_range(n, ocp_pkg::GENE_CNT - 1);
                end
            end
            SET_REPEAT: begin
                if (n >= 2) begin
                    i = $urandom_range(0, n - 1);
                    j = (i + 1 + $urandom_range(0, n - 2)) % n;
                    if ($urandom_range(0, 1)) pa[j] = pa[i];
                    else pb[j] = pb[i];
                end
            end
            SET_NOISE: begin
                for (i = 0; i < n; i++) begin
                    pa[i] = $urandom_range(0, ocp_pkg::GENE_CNT - 1);
                    pb[i] = $urandom_range(0, ocp_pkg::GENE_CNT - 1);
                end
            end
            default: ;
        endcase
        for (i = 0; i < n; i++)
            push_beat(pa[i], pb[i],
                      (i == 0) ? cut : $urandom_range(0, ocp_pkg::GENE_CNT - 1),
                      i == n - 1, drain && i == 0);
    endtask

    // -----------------------------------------------------------------------
    // Parent driver
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : drive_parents
        bit offer;
        bit may_start;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (beat_q[0].last_position)
                    sets_sent++;
                beat_q.delete(0);
            end
            if (src_phase_left == 0) begin
                src_chop = $urandom_range(0, 1);
                src_phase_left = $urandom_range(20, 80);
            end else begin
                src_phase_left--;
            end
            may_start = beat_q.size() != 0 &&
                        !(beat_q[0].wait_drain && sets_done != sets_sent);
            offer = 1'b0;
            if (s_valid && !s_ready) begin
                offer = 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
            end else if (may_start) begin
                if (src_chop && beat_q.size() >= TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(0, 12);
                end else begin
                    offer = 1'b1;
                    s_first_gene    <= beat_q[0].first_gene;
                    s_second_gene   <= beat_q[0].second_gene;
                    s_cut_point     <= beat_q[0].cut_point;
                    s_last_position <= beat_q[0].last_position;
                end
            end
            s_valid    <= offer;
            tail_quiet <= beat_q.size() < TAIL_ITEMS;
        end
    end

    // -----------------------------------------------------------------------
    // Child sink: random bursts plus one long hold-off
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : drive_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (snk_phase_left == 0) begin
                snk_chop = $urandom_range(0, 1);
                snk_phase_left = $urandom_range(20, 80);
            end else begin
                snk_phase_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (snk_chop && !tail_quiet && $urandom_range(0, 4) == 0) begin
                snk_gap = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: check child beats, then feed accepted parent beats to predictor
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : watch_beats
        child_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (child_q.size() == 0) begin
                    report_mismatch("child beat with nothing expected", m_child_one_gene, 0);
                end else begin
                    want = child_q.pop_front();
                    if (m_child_one_gene !== want.child_one)
                        report_mismatch("child one gene", m_child_one_gene, want.child_one);
                    if (m_child_two_gene !== want.child_two)
                        report_mismatch("child two gene", m_child_two_gene, want.child_two);
                    if (m_final_gene !== want.final_gene)
                        report_mismatch("final gene flag", m_final_gene, want.final_gene);
                    if (m_bad_parents !== want.bad)
                        report_mismatch("bad parents flag", m_bad_parents, want.bad);
                    if (want.final_gene)
                        sets_done <= sets_done + 1;
                end
                results_seen <= results_seen + 1;
            end
            if (s_valid && s_ready)
                absorb_parent_beat(s_first_gene, s_second_gene, s_cut_point, s_last_position);
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog on cycles without any accepted beat
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("order_crossover_permutation test failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus, reset and end of run
    // -----------------------------------------------------------------------
    initial begin : run_test
        int set_idx, n, r, cut;
        set_kind_t kind;

        // directed sets
        push_set(1, 0, SET_CLEAN, 1'b0);            // single position
        push_set(2, 63, SET_CLEAN, 1'b0);           // cut saturates
        push_set(5, 1, SET_CLEAN, 1'b0);
        push_beat(63, 2, 5, 1'b0, 1'b0);            // genes out of range, cut saturates
        push_beat(1, 63, 0, 1'b0, 1'b0);
        push_beat(0, 0, 0, 1'b1, 1'b0);
        push_set(4, 2, SET_REPEAT, 1'b0);
        push_set(6, 5, SET_CLEAN, 1'b0);            // cut at the last position
        push_set(3, 0, SET_NOISE, 1'b0);

        // random sets; the first waits for the directed children to drain
        set_idx = 0;
        while (items_queued < ITEM_TARGET || set_idx < 12) begin
            if (set_idx == 4) begin
                push_set(ocp_pkg::MAX_GENES_DEF, $urandom_range(0, 63), SET_CLEAN, 1'b0);
            end else if (set_idx == 9) begin
                // overflow: extra beats are dropped
                push_set(ocp_pkg::MAX_GENES_DEF + 2, $urandom_range(0, 63), SET_CLEAN, 1'b0);
            end else begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
                r = $urandom_range(0, 9);
                kind = (r < 7) ? SET_CLEAN : (r == 7) ? SET_RANGE :
                       (r == 8) ? SET_REPEAT : SET_NOISE;
                r = $urandom_range(0, 4);
                cut = (r < 3) ? $urandom_range(0, n - 1) : (r == 3) ? n - 1 :
                      $urandom_range(0, 63);
                push_set(n, cut, kind, set_idx == 0);
            end
            set_idx++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // all parents accepted, then all children back, then settle
        while (beat_q.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
        while (sets_done != sets_sent)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (child_q.size() != 0)
            report_mismatch("child beats never arrived", 0, child_q.size());

        if (mismatch_count == 0)
            $display("order_crossover_permutation test passed");
        else
            $display("order_crossover_permutation test failed");
        $finish;
    end

endmodule
